// ===== sv/pms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, widths, the note tables and the controller/datapath links
// for the melody sequencer.
// ----------------------------------------------------------------------------
package pms_pkg;

	// field widths
	localparam int TICK_W      = 28;
	localparam int NOW_W       = 32;
	localparam int NUM_W       = 3;
	localparam int VAL_W       = 16;
	localparam int FREQ_W      = 11;
	localparam int LEN_W       = 10;

	// melody length and note position counter
	localparam int NOTE_COUNT  = 8;
	localparam int NOTE_POS_W  = 6;
	localparam int POS_CMP_W   = NOTE_POS_W + 1;

	// period division: (tick + freq/2) / freq
	localparam int QUO_W       = TICK_W + 1;
	localparam int DIV_CNT_W   = $clog2(QUO_W);
	localparam int PERIOD_MIN  = 2;
	localparam int PERIOD_MAX  = 65536;

	localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000000);

	// command codes
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_UPDATE = 2'd1,
		OP_STOP   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic step;
		logic div_start;
		logic apply;
		logic out_load;
	} pms_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic step_done;
		logic need_load;
		logic div_done;
		logic out_free;
	} pms_stat_t;

	// tone frequency in Hz for each ROM slot
	function automatic logic [FREQ_W-1:0] tone_freq(input logic [NUM_W-1:0] idx);
		logic [FREQ_W-1:0] f;
		unique case (idx)
			3'd0: f = 11'd523;
			3'd1: f = 11'd659;
			3'd2: f = 11'd784;
			3'd3: f = 11'd1047;
			3'd4: f = 11'd784;
			3'd5: f = 11'd659;
			3'd6: f = 11'd587;
			3'd7: f = 11'd523;
			default: f = 11'd523;
		endcase
		return f;
	endfunction

	// note length in ms for each ROM slot
	function automatic logic [LEN_W-1:0] tone_len(input logic [NUM_W-1:0] idx);
		logic [LEN_W-1:0] l;
		unique case (idx)
			3'd3, 3'd7: l = 10'd1000;
			default:    l = 10'd500;
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

// ===== sv/pwm_melody_sequencer_core.sv =====
`default_nettype none
// Stop and unused commands go straight to the output register; start runs
// the serial period divider; update first steps once per elapsed note and
// then runs the divider when a new tone is loaded.
// One item at a time: the next item is taken once the result has moved
// into the output register.
// arst_n clears playback, sets the tick rate to 1000000 and leaves the block idle and ready.
// ----------------------------------------------------------------------------
// pwm_melody_sequencer_core
// Eight-note melody sequencer driving PWM reload and compare values from
// start, update and stop commands with millisecond timestamps.
// ----------------------------------------------------------------------------
module pwm_melody_sequencer_core
	import pms_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [TICK_W-1:0] cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        op,
	input  wire logic [NOW_W-1:0]  now_ms,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   playing,
	output logic [NUM_W-1:0]       note_number,
	output logic                   tone_load,
	output logic [VAL_W-1:0]       reload_value,
	output logic [VAL_W-1:0]       compare_value,
	output logic                   pwm_on
);

	pms_cmd_t  cmd;
	pms_stat_t stat;

	// controller
	pms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	pms_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.op            (op),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.playing       (playing),
		.note_number   (note_number),
		.tone_load     (tone_load),
		.reload_value  (reload_value),
		.compare_value (compare_value),
		.pwm_on        (pwm_on)
	);

endmodule
`default_nettype wire

// ===== sv/pms_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_divider
// Restoring divider, one quotient bit per cycle. done pulses for one cycle
// once the quotient is final.
// ----------------------------------------------------------------------------
module pms_divider
	import pms_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [QUO_W-1:0]  dividend,
	input  wire logic [FREQ_W-1:0] divisor,
	output logic                   done,
	output logic [QUO_W-1:0]       quotient
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(QUO_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FREQ_W-1:0]    rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [FREQ_W:0]      trial;
	logic                 fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? FREQ_W'(trial - {1'b0, divisor}) : trial[FREQ_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== sv/pms_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_datapath
// Playback state, note catch-up arithmetic, period division, tone registers
// and the output register.
// ----------------------------------------------------------------------------
module pms_datapath
	import pms_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pms_cmd_t          cmd,
	output pms_stat_t              stat,
	input  wire logic              cfg_wr_en,
	input  wire logic [TICK_W-1:0] cfg_wr_data,
	input  wire logic [1:0]        op,
	input  wire logic [NOW_W-1:0]  now_ms,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   playing,
	output logic [NUM_W-1:0]       note_number,
	output logic                   tone_load,
	output logic [VAL_W-1:0]       reload_value,
	output logic [VAL_W-1:0]       compare_value,
	output logic                   pwm_on
);

	localparam logic [POS_CMP_W-1:0] POS_END = POS_CMP_W'(NOTE_COUNT);

	logic [TICK_W-1:0]     tick_q;
	logic [NOW_W-1:0]      now_q;
	logic [NOW_W-1:0]      start_q;
	logic [NOTE_POS_W-1:0] pos_q;
	logic                  active_q;
	logic                  changed_q;
	logic                  loaded_q;
	logic [VAL_W-1:0]      reload_q;
	logic [VAL_W-1:0]      compare_q;

	logic                  out_valid_q;
	logic                  out_playing_q;
	logic [NUM_W-1:0]      out_num_q;
	logic                  out_load_q;
	logic [VAL_W-1:0]      out_reload_q;
	logic [VAL_W-1:0]      out_compare_q;

	logic [NOW_W-1:0]      elapsed;
	logic [LEN_W-1:0]      cur_len;
	logic [FREQ_W-1:0]     cur_freq;
	logic [POS_CMP_W-1:0]  pos_inc;
	logic                  pos_last;
	logic [QUO_W-1:0]      dividend;
	logic                  div_done;
	logic [QUO_W-1:0]      period;
	logic [QUO_W-1:0]      period_m1;
	logic                  period_ok;
	op_t                   op_in;

	assign op_in = op_t'(op);

	// note timing
	assign cur_len  = tone_len(pos_q[NUM_W-1:0]);
	assign cur_freq = tone_freq(pos_q[NUM_W-1:0]);
	assign elapsed  = now_q - start_q;
	assign pos_inc  = {1'b0, pos_q} + POS_CMP_W'(1);
	assign pos_last = pos_inc >= POS_END;

	// rounded period: (tick + freq/2) / freq
	assign dividend = QUO_W'(tick_q) + QUO_W'(cur_freq >> 1);

	pms_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (cur_freq),
		.done     (div_done),
		.quotient (period)
	);

	assign period_m1 = period - QUO_W'(1);
	assign period_ok = (period >= QUO_W'(PERIOD_MIN)) && (period <= QUO_W'(PERIOD_MAX));

	// status to the controller
	assign stat.step_done = !active_q || (elapsed < NOW_W'(cur_len));
	assign stat.need_load = changed_q && active_q;
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_valid_q || out_ready;

	// tick rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tick_q <= TICK_RESET;
		else if (cfg_wr_en)
			tick_q <= cfg_wr_data;
	end

	// playback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q     <= '0;
			start_q   <= '0;
			pos_q     <= '0;
			active_q  <= 1'b0;
			changed_q <= 1'b0;
			loaded_q  <= 1'b0;
			reload_q  <= '0;
			compare_q <= '0;
		end else begin
			if (cmd.capture) begin
				now_q     <= now_ms;
				changed_q <= 1'b0;
				loaded_q  <= 1'b0;
				unique case (op_in)
					OP_START: begin
						pos_q    <= '0;
						start_q  <= now_ms;
						active_q <= 1'b1;
					end
					OP_STOP: begin
						compare_q <= '0;
						active_q  <= 1'b0;
					end
					OP_UPDATE, OP_NONE: begin
					end
					default: begin
					end
				endcase
			end
			// one catch-up step per cycle
			if (cmd.step) begin
				start_q <= start_q + NOW_W'(cur_len);
				if (pos_last) begin
					compare_q <= '0;
					active_q  <= 1'b0;
				end else begin
					pos_q     <= pos_inc[NOTE_POS_W-1:0];
					changed_q <= 1'b1;
				end
			end
			// take the divider result
			if (cmd.apply) begin
				if (period_ok) begin
					reload_q  <= period_m1[VAL_W-1:0];
					compare_q <= period[VAL_W:1];
					loaded_q  <= 1'b1;
				end else begin
					compare_q <= '0;
					active_q  <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_playing_q <= active_q;
			out_num_q     <= pos_q[NUM_W-1:0];
			out_load_q    <= loaded_q;
			out_reload_q  <= reload_q;
			out_compare_q <= compare_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign playing       = out_playing_q;
	assign pwm_on        = out_playing_q;
	assign note_number   = out_num_q;
	assign tone_load     = out_load_q;
	assign reload_value  = out_reload_q;
	assign compare_value = out_compare_q;

`ifndef NO_ASSERTIONS
	// a sounding note always has a nonzero compare
	a_play_compare: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_playing_q |-> out_compare_q != '0)
		else $error("playing with zero compare");

	// a freshly loaded tone leaves playback running
	a_load_plays: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_load_q |-> out_playing_q)
		else $error("tone loaded while stopped");

	// catch-up only runs while playing
	a_step_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> active_q)
		else $error("catch-up step while idle");
`endif

endmodule
`default_nettype wire

// ===== sv/pms_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer for one command item: capture, note catch-up, period division
// and hand-off to the output register.
// ----------------------------------------------------------------------------
module pms_ctrl
	import pms_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] op,
	input  wire pms_stat_t  stat,
	output pms_cmd_t        cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_STEP   = 5'b00010,
		S_LOAD   = 5'b00100,
		S_DIVW   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	op_t    op_in;

	assign op_in = op_t'(op);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (op_in)
						OP_START:  state_d = S_LOAD;
						OP_UPDATE: state_d = S_STEP;
						OP_STOP, OP_NONE: state_d = S_FINISH;
						default:   state_d = S_FINISH;
					endcase
				end
			end
			S_STEP: begin
				if (stat.step_done)
					state_d = stat.need_load ? S_LOAD : S_FINISH;
			end
			S_LOAD:   state_d = S_DIVW;
			S_DIVW: begin
				if (stat.div_done)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free)
					state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// commands
	assign in_ready      = (state_q == S_IDLE);
	assign cmd.capture   = (state_q == S_IDLE) && in_valid;
	assign cmd.step      = (state_q == S_STEP) && !stat.step_done;
	assign cmd.div_start = (state_q == S_LOAD);
	assign cmd.apply     = (state_q == S_DIVW) && stat.div_done;
	assign cmd.out_load  = (state_q == S_FINISH) && stat.out_free;

`ifndef NO_ASSERTIONS
	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");
`endif

endmodule
`default_nettype wire
